// File: rtl/core/vlmf_pkg.sv
// Shared constants and control types for the variable length message FIFO.
`timescale 1ns / 1ps
package vlmf_pkg;

  localparam int SLOTS_DEF    = 16;
  localparam int MAX_ITEM_DEF = 255;

  localparam logic [4:0] SLOT_COUNT_RST = 5'd16;
  localparam logic [7:0] MSG_LIMIT_RST  = 8'd255;

  localparam logic [8:0] OFFSET_MAX = 9'd511;

  localparam logic REG_SLOT_COUNT = 1'b0;
  localparam logic REG_MSG_LIMIT  = 1'b1;

  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_PENDING  = 3'd1;
  localparam logic [2:0] ST_TOO_LONG = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_EVT_REF  = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;

  typedef struct packed {
    logic send_go;
    logic read_go;
  } vlmf_cmd_t;

  typedef struct packed {
    logic in_read;
  } vlmf_stat_t;

endpackage

// File: rtl/core/vlmf_ifs.sv
// Request and response stream interfaces of the message FIFO.
`timescale 1ns / 1ps
interface vlmf_req_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] in_byte;
  logic       end_of_message;
  logic       event_ok;

  modport source (output valid, command, in_byte, end_of_message, event_ok, input ready);
  modport sink (input valid, command, in_byte, end_of_message, event_ok, output ready);
endinterface

interface vlmf_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] out_byte;
  logic       last_byte;
  logic [7:0] msg_length;

  modport source (output valid, status, out_byte, last_byte, msg_length, input ready);
  modport sink (input valid, status, out_byte, last_byte, msg_length, output ready);
endinterface

// File: rtl/core/vlmf_ram.sv
// Generic simple dual port RAM with registered read.
`timescale 1ns / 1ps
module vlmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/vlmf_ctrl.sv
// Controller: input acceptance, read sequencing and response valid.
`timescale 1ns / 1ps
module vlmf_ctrl import vlmf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  vlmf_stat_t stat,
  output vlmf_cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state, state_next;
  logic out_valid_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (stat.in_read) begin
            state_next = S_READ;
          end else begin
            cmd.send_go    = 1'b1;
            out_valid_next = 1'b1;
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          cmd.read_go    = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: rtl/core/vlmf_dp.sv
// Datapath: ring pointers, message and length memories, response register.
`timescale 1ns / 1ps
module vlmf_dp import vlmf_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int MAX_ITEM = MAX_ITEM_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  vlmf_cmd_t  cmd,
  output vlmf_stat_t stat,
  input  logic [4:0] slot_count,
  input  logic [7:0] msg_limit,
  input  logic       command,
  input  logic [7:0] in_byte,
  input  logic       end_of_message,
  input  logic       event_ok,
  output logic [2:0] status,
  output logic [7:0] out_byte,
  output logic       last_byte,
  output logic [7:0] msg_length
);

  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int STORE_DEPTH = SLOTS * 256;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  logic [SLOT_W-1:0] read_slot, read_slot_next;
  logic [CNT_W-1:0]  fill_count, fill_count_next;
  logic [8:0]        write_offset, write_offset_next;
  logic [7:0]        read_offset, read_offset_next;
  logic              write_blocked, write_blocked_next;

  logic [CNT_W-1:0]  ns;
  logic [7:0]        isz;
  logic              bad, full;
  logic [31:0]       tail_sum;
  logic [SLOT_W-1:0] tail;
  logic [9:0]        wlen;
  logic [8:0]        rd_next_off;

  logic              store_we, len_we;
  logic [7:0]        store_q, len_q;
  logic [SLOT_W+7:0] store_wide_w, store_wide_r;

  logic [2:0] status_next;
  logic [7:0] out_byte_next, msg_length_next;
  logic       last_byte_next;

  assign stat.in_read = (command == CMD_READ);

  always_comb begin
    if (slot_count == '0) begin
      ns = CNT_W'(1);
    end else if (32'(slot_count) > 32'(SLOTS)) begin
      ns = CNT_W'(SLOTS);
    end else begin
      ns = CNT_W'(slot_count);
    end
    isz = (32'(msg_limit) > 32'(MAX_ITEM)) ? 8'(MAX_ITEM) : msg_limit;
  end

  assign bad  = (32'(read_slot) >= 32'(ns)) || (fill_count > ns);
  assign full = bad || (fill_count >= ns);

  always_comb begin
    tail_sum = 32'(read_slot) + 32'(fill_count);
    if (tail_sum >= 32'(ns)) begin
      tail_sum = tail_sum - 32'(ns);
    end
    if (bad || tail_sum >= 32'(SLOTS)) begin
      tail = '0;
    end else begin
      tail = SLOT_W'(tail_sum);
    end
  end

  assign wlen        = {1'b0, write_offset} + 10'd1;
  assign rd_next_off = {1'b0, read_offset} + 9'd1;

  assign store_we     = cmd.send_go && !full && (write_offset < {1'b0, isz});
  assign store_wide_w = {tail, write_offset[7:0]};
  assign store_wide_r = {read_slot, read_offset};

  vlmf_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (STORE_AW'(store_wide_w)),
    .wdata (in_byte),
    .raddr (STORE_AW'(store_wide_r)),
    .rdata (store_q)
  );

  vlmf_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_len (
    .clk   (clk),
    .we    (len_we),
    .waddr (tail),
    .wdata (wlen[7:0]),
    .raddr (read_slot),
    .rdata (len_q)
  );

  always_comb begin
    read_slot_next     = read_slot;
    fill_count_next    = fill_count;
    write_offset_next  = write_offset;
    read_offset_next   = read_offset;
    write_blocked_next = write_blocked;
    len_we             = 1'b0;
    status_next        = status;
    out_byte_next      = out_byte;
    last_byte_next     = last_byte;
    msg_length_next    = msg_length;

    if (cmd.send_go) begin
      out_byte_next   = '0;
      last_byte_next  = 1'b0;
      msg_length_next = '0;
      if (full) begin
        write_blocked_next = 1'b1;
      end
      if (!end_of_message) begin
        if (write_offset != OFFSET_MAX) begin
          write_offset_next = write_offset + 9'd1;
        end
        status_next = ST_PENDING;
      end else begin
        priority if (bad || isz == '0 || wlen > {2'b0, isz}) begin
          status_next = ST_TOO_LONG;
        end else if (full || write_blocked) begin
          status_next = ST_FULL;
        end else begin
          len_we = 1'b1;
          if (event_ok) begin
            fill_count_next = fill_count + CNT_W'(1);
            status_next     = ST_OK;
          end else begin
            status_next = ST_EVT_REF;
          end
        end
        write_offset_next  = '0;
        write_blocked_next = 1'b0;
      end
    end else if (cmd.read_go) begin
      if (bad || fill_count == '0) begin
        status_next     = ST_EMPTY;
        out_byte_next   = '0;
        last_byte_next  = 1'b0;
        msg_length_next = '0;
      end else begin
        status_next     = ST_OK;
        out_byte_next   = store_q;
        msg_length_next = len_q;
        if (rd_next_off >= {1'b0, len_q}) begin
          last_byte_next   = 1'b1;
          read_offset_next = '0;
          fill_count_next  = fill_count - CNT_W'(1);
          if (32'(read_slot) + 32'd1 >= 32'(ns)) begin
            read_slot_next = '0;
          end else begin
            read_slot_next = read_slot + SLOT_W'(1);
          end
        end else begin
          last_byte_next   = 1'b0;
          read_offset_next = rd_next_off[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_slot     <= '0;
      fill_count    <= '0;
      write_offset  <= '0;
      read_offset   <= '0;
      write_blocked <= 1'b0;
    end else begin
      read_slot     <= read_slot_next;
      fill_count    <= fill_count_next;
      write_offset  <= write_offset_next;
      read_offset   <= read_offset_next;
      write_blocked <= write_blocked_next;
    end
  end

  always_ff @(posedge clk) begin
    status     <= status_next;
    out_byte   <= out_byte_next;
    last_byte  <= last_byte_next;
    msg_length <= msg_length_next;
  end

endmodule

// File: rtl/core/variable_length_message_fifo.sv
// Top level of the variable length message FIFO with its register port.
//
// Requests arrive on req: a send beat writes in_byte into the tail slot, a
// read beat fetches the next byte of the head message. Every request beat
// gives exactly one response beat on rsp carrying status, out_byte,
// last_byte and msg_length.
// A send beat shows its response in the cycle after acceptance. A read beat
// first passes through S_READ, which waits for the registered read of the
// message and length memories. req.ready is high while no read is in flight
// and the response register is empty or being drained in that cycle, so
// sends run at one beat per cycle while rsp drains, and reads do not overlap.
// When rsp stalls, the response is held and no new request is taken.
// Reset (rst, synchronous) empties the ring and restores slot_count to 16
// and the message length limit to 255; memory contents are not cleared and
// need no pass. Registers: slot_count at byte address 0, message length
// limit at byte address 4, written over the APB-style port; the user must
// write them only while the block is idle, which the block does not enforce.
`timescale 1ns / 1ps
module variable_length_message_fifo import vlmf_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int MAX_ITEM = MAX_ITEM_DEF
) (
  input  logic        clk,
  input  logic        rst,
  vlmf_req_if.sink    req,
  vlmf_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0] slot_count;
  logic [7:0] msg_limit;
  logic       cfg_we;
  vlmf_cmd_t  cmd;
  vlmf_stat_t stat;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= SLOT_COUNT_RST;
      msg_limit  <= MSG_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_SLOT_COUNT: slot_count <= pwdata[4:0];
        REG_MSG_LIMIT:  msg_limit  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SLOT_COUNT: prdata = {27'd0, slot_count};
      REG_MSG_LIMIT:  prdata = {24'd0, msg_limit};
      default:        prdata = '0;
    endcase
  end

  vlmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  vlmf_dp #(.SLOTS(SLOTS), .MAX_ITEM(MAX_ITEM)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .slot_count     (slot_count),
    .msg_limit      (msg_limit),
    .command        (req.command),
    .in_byte        (req.in_byte),
    .end_of_message (req.end_of_message),
    .event_ok       (req.event_ok),
    .status         (rsp.status),
    .out_byte       (rsp.out_byte),
    .last_byte      (rsp.last_byte),
    .msg_length     (rsp.msg_length)
  );

endmodule
